>>> sv/ssc_pkg.sv
// shared types and constants for the signed sum solution counter
// no dependencies; imported by the enumerator and the top level
`default_nettype none

package ssc_pkg;

   // field widths fixed by the interface
   localparam int VALUE_W = 16;
   localparam int TOTAL_W = 21;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // enumerator status back to the control sequencer
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] count;
   } enum_status_type;

endpackage

`default_nettype wire

>>> sv/ssc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ssc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/ssc_enum.sv
// gray code sign pattern enumerator: one pattern per cycle from the value ram
// depends on ssc_pkg; reads the value store through the top level's ram
`default_nettype none

module ssc_enum #(
   parameter int MAX_VALUES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [MAX_VALUES-1:0]                 masks,
   input  wire logic signed [ssc_pkg::TOTAL_W-1:0]    init_total,
   input  wire logic signed [ssc_pkg::TOTAL_W-1:0]    target,
   output logic                                       rd_en,
   output logic      [$clog2(MAX_VALUES)-1:0]         rd_addr,
   input  wire logic [ssc_pkg::VALUE_W-1:0]           rd_data,
   output ssc_pkg::enum_status_type                   status
);

   import ssc_pkg::*;

   localparam int IDX_W  = MAX_VALUES;
   localparam int ADDR_W = $clog2(MAX_VALUES);

   // position of the single set bit of a one-hot word
   function automatic logic [ADDR_W-1:0] onehot_pos(input logic [IDX_W-1:0] oh);
      logic [ADDR_W-1:0] pos;
      pos = '0;
      for (int b = 0; b < IDX_W; b++) begin
         if (oh[b]) begin
            pos = pos | ADDR_W'(b);
         end
      end
      return pos;
   endfunction

   logic                      busy_ff,    busy_in;
   logic [IDX_W-1:0]          idx_ff,     idx_in;
   logic [IDX_W-1:0]          masks_ff,   masks_in;
   logic                      rd_vld_ff,  rd_vld_in;
   logic                      add_ff,     add_in;
   logic signed [TOTAL_W-1:0] tot_ff,     tot_in;
   logic                      tot_vld_ff, tot_vld_in;
   logic [COUNT_W-1:0]        count_ff,   count_in;
   logic                      done_ff,    done_in;

   logic [IDX_W-1:0]          low_bit;
   logic                      issue;
   logic signed [TOTAL_W-1:0] step;

   // lowest set bit of the pattern index picks the sign that flips
   assign low_bit = idx_ff & (~idx_ff + IDX_W'(1));
   assign issue   = busy_ff && (idx_ff != masks_ff);
   assign rd_en   = issue;
   assign rd_addr = onehot_pos(low_bit) + ADDR_W'(1);

   // twice the value read back, sign extended
   assign step = {{(TOTAL_W-VALUE_W-1){rd_data[VALUE_W-1]}}, rd_data, 1'b0};

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      masks_in   = masks_ff;
      rd_vld_in  = 1'b0;
      add_in     = add_ff;
      tot_in     = tot_ff;
      tot_vld_in = 1'b0;
      count_in   = count_ff;
      done_in    = 1'b0;
      if (start) begin
         busy_in    = 1'b1;
         idx_in     = IDX_W'(1);
         masks_in   = masks;
         tot_in     = init_total;
         tot_vld_in = 1'b1;
         count_in   = '0;
      end else if (busy_ff) begin
         // issue the read for the next pattern
         if (issue) begin
            rd_vld_in = 1'b1;
            add_in    = ((low_bit << 1) & idx_ff) == '0;
            idx_in    = idx_ff + IDX_W'(1);
         end
         // apply the flipped sign to the running total
         if (rd_vld_ff) begin
            tot_in     = add_ff ? tot_ff + step : tot_ff - step;
            tot_vld_in = 1'b1;
         end
         // count a matching pattern, saturating
         if (tot_vld_ff && (tot_ff == target) && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (!issue && !rd_vld_ff && !tot_vld_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rd_vld_ff  <= 1'b0;
         tot_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         rd_vld_ff  <= rd_vld_in;
         tot_vld_ff <= tot_vld_in;
         done_ff    <= done_in;
      end
      idx_ff   <= idx_in;
      masks_ff <= masks_in;
      add_ff   <= add_in;
      tot_ff   <= tot_in;
      count_ff <= count_in;
   end

   assign status = '{done: done_ff, count: count_ff};

endmodule

`default_nettype wire

>>> sv/signed_sum_solution_counter.sv
// Signed sum solution counter, top level.
// Channels: req_ (value, is_last) loads one list element per beat; the element
// marked is_last closes the list. rsp_ carries one beat per list with
// solution_count and too_few. csr_ writes target_sum; csr_ready is always high.
// Loading takes elements back to back; req_ready is high while loading.
// After the last element of a list of n values (n capped at MAX_VALUES) the
// block enumerates all 2^(n-1) sign patterns in gray code order, one pattern
// per cycle, set by the single read port of the value ram. A list shorter
// than two values skips the enumeration and gives its result with too_few
// set and a zero count.
// Values beyond MAX_VALUES in one list are dropped.
// Reset (synchronous, active high) clears the load count, the target and all
// handshake state; the value ram needs no clearing pass.
// If the receiver stalls, the result beat is held in the output register;
// the next list may be loaded meanwhile, and its result waits for the slot.
`default_nettype none

module signed_sum_solution_counter #(
   parameter int MAX_VALUES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ssc_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                req_is_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [ssc_pkg::COUNT_W-1:0]         rsp_solution_count,
   output logic                                     rsp_too_few,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic signed [ssc_pkg::TOTAL_W-1:0]  csr_target_sum
);

   import ssc_pkg::*;

   localparam int IDX_W  = MAX_VALUES;
   localparam int ADDR_W = $clog2(MAX_VALUES);
   localparam int CNT_W  = $clog2(MAX_VALUES + 1);

   typedef enum logic [1:0] {
      S_LOAD,
      S_RUN,
      S_DONE
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          loaded_ff;
   logic signed [TOTAL_W-1:0] init_ff;
   logic signed [TOTAL_W-1:0] target_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      few_ff;
   logic                      rsp_valid_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_few_ff;

   logic                      req_acc;
   logic                      has_room;
   logic signed [TOTAL_W-1:0] value_ext;
   logic signed [TOTAL_W-1:0] init_in;
   logic [IDX_W-1:0]          masks_in;
   logic                      start;
   logic                      rsp_load;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]        rd_data;
   enum_status_type           status;

   assign req_ready = (state_ff == S_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign has_room  = loaded_ff < CNT_W'(MAX_VALUES);
   assign value_ext = TOTAL_W'(req_value);

   // first value takes a plus sign, the rest start as minus (pattern zero)
   always_comb begin
      init_in = init_ff;
      if (loaded_ff == '0) begin
         init_in = value_ext;
      end else if (has_room) begin
         init_in = init_ff - value_ext;
      end
   end

   // number of patterns: 2^(n-1), n being the stored count after this beat
   assign masks_in = has_room ? (IDX_W'(1) << loaded_ff)
                              : (IDX_W'(1) << (MAX_VALUES - 1));

   assign start = req_acc && req_is_last && (loaded_ff != '0);

   // result slot takes a new beat when empty or being drained
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   ssc_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_VALUES)
   ) u_value_ram (
      .clock  (clock),
      .wr_en  (req_acc && has_room),
      .wr_addr(loaded_ff[ADDR_W-1:0]),
      .wr_data(req_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ssc_enum #(
      .MAX_VALUES(MAX_VALUES)
   ) u_enum (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .masks     (masks_in),
      .init_total(init_in),
      .target    (target_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .status    (status)
   );

   // sequencer, load bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            target_ff <= csr_target_sum;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  init_ff <= init_in;
                  if (req_is_last) begin
                     loaded_ff <= '0;
                     if (loaded_ff == '0) begin
                        few_ff   <= 1'b1;
                        count_ff <= '0;
                        state_ff <= S_DONE;
                     end else begin
                        few_ff   <= 1'b0;
                        state_ff <= S_RUN;
                     end
                  end else if (has_room) begin
                     loaded_ff <= loaded_ff + CNT_W'(1);
                  end
               end
            end
            S_RUN: begin
               if (status.done) begin
                  count_ff <= status.count;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_count_ff <= count_ff;
                  rsp_few_ff   <= few_ff;
                  state_ff     <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_count = rsp_count_ff;
   assign rsp_too_few        = rsp_few_ff;

   // the value ram is only read while patterns are being enumerated
   a_read_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == S_RUN))
      else $error("value ram read outside enumeration");

   // a short list never reports a nonzero count
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_few) |-> (rsp_solution_count == '0))
      else $error("short list with nonzero count");

   // enumeration finishes only while the sequencer waits for it
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == S_RUN))
      else $error("enumerator done outside enumeration");

endmodule

`default_nettype wire
